### sv/msep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI stream event parser package
// Shared types, status byte codes and small decode functions.
// ----------------------------------------------------------------------------
package msep_pkg;

  // Status bytes and event codes
  localparam logic [7:0] ST_NONE      = 8'h00;
  localparam logic [7:0] ST_SYSTEM    = 8'hF0;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] OP_RESET     = 8'hFF;
  localparam logic [7:0] OP_NOTE_OFF  = 8'h80;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [7:0] VEL_RELEASE  = 8'h40;
  localparam logic [4:0] CHAN_ALL     = 5'd16;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [7:0] status;
    logic [1:0] pending;
    logic [7:0] first_param;
  } msep_state_t;

  // One decoded event
  typedef struct packed {
    logic [7:0] opcode;
    logic [4:0] channel;
    logic [7:0] param_a;
    logic [7:0] param_b;
  } msep_event_t;

  // Number of parameter bytes that follow a status byte.
  function automatic logic [1:0] params_needed(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    case (s[7:4]) inside
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
      4'hC, 4'hD:                   n = 2'd1;
      default: begin
        if (s == ST_SONG_POS) begin
          n = 2'd2;
        end else if (s == ST_SONG_SEL) begin
          n = 2'd1;
        end
      end
    endcase
    return n;
  endfunction

  // Builds the event for a completed message; note-on with velocity zero
  // is reported as note-off with the default release velocity.
  function automatic msep_event_t build_msg(input logic [7:0] s, input logic [7:0] a,
                                            input logic [7:0] b);
    msep_event_t ev;
    if (s >= ST_SYSTEM) begin
      ev = '{opcode: s, channel: CHAN_ALL, param_a: a, param_b: b};
    end else if (s[7:4] == NIB_NOTE_ON && b == 8'h00) begin
      ev = '{opcode: OP_NOTE_OFF, channel: {1'b0, s[3:0]}, param_a: a,
             param_b: VEL_RELEASE};
    end else begin
      ev = '{opcode: {s[7:4], 4'h0}, channel: {1'b0, s[3:0]}, param_a: a, param_b: b};
    end
    return ev;
  endfunction

endpackage

### sv/msep_decode.sv
// ----------------------------------------------------------------------------
// MIDI byte decoder
// Combinational step of the parser: next state and optional event per byte.
// ----------------------------------------------------------------------------
module msep_decode
  import msep_pkg::*;
(
  input  msep_state_t st,
  input  logic [7:0]  byte_in,
  output msep_state_t st_nxt,
  output logic        emit,
  output msep_event_t ev
);

  logic [1:0]  need_s;
  logic [1:0]  need_v;
  msep_event_t reset_ev;

  assign need_s   = params_needed(st.status);
  assign need_v   = params_needed(byte_in);
  assign reset_ev = '{opcode: OP_RESET, channel: CHAN_ALL, param_a: 8'h00, param_b: 8'h00};

  // Byte decode
  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    ev     = reset_ev;

    if (st.pending != 2'd0) begin
      // A message is in progress: any byte is its next parameter.
      if (st.pending >= 2'd2) begin
        st_nxt.first_param = byte_in;
        st_nxt.pending     = 2'd1;
      end else begin
        st_nxt.pending = 2'd0;
        emit           = 1'b1;
        if (need_s == 2'd2) begin
          ev = build_msg(st.status, st.first_param, byte_in);
        end else begin
          ev = build_msg(st.status, byte_in, 8'h00);
        end
        if (st.status >= ST_SYSTEM) begin
          st_nxt.status = ST_NONE;
        end
      end
    end else if (st.status == ST_SYSEX && byte_in != ST_EOX) begin
      // Sysex data passes through one byte at a time.
      emit = 1'b1;
      ev   = '{opcode: ST_SYSEX, channel: CHAN_ALL, param_a: byte_in, param_b: 8'h00};
    end else if (byte_in[7]) begin
      // Status byte
      st_nxt.status = byte_in;
      if (byte_in < ST_SYSTEM) begin
        st_nxt.pending = need_v;
      end else begin
        case (byte_in) inside
          ST_SYSEX: begin
            emit = 1'b1;
            ev   = '{opcode: ST_SYSEX, channel: CHAN_ALL, param_a: 8'h00, param_b: 8'h00};
          end
          ST_SONG_POS, ST_SONG_SEL: begin
            st_nxt.pending = need_v;
          end
          8'hF6, 8'hF7, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: begin
            st_nxt.status = ST_NONE;
            emit          = 1'b1;
            ev = '{opcode: byte_in, channel: CHAN_ALL, param_a: 8'h00, param_b: 8'h00};
          end
          default: begin
            // Undefined system status drops the byte and resets.
            st_nxt.status = ST_NONE;
            emit          = 1'b1;
          end
        endcase
      end
    end else begin
      // Data byte under running status
      if (st.status == ST_NONE || st.status >= ST_SYSTEM || need_s == 2'd0) begin
        st_nxt.status = ST_NONE;
        emit          = 1'b1;
      end else if (need_s == 2'd2) begin
        st_nxt.first_param = byte_in;
        st_nxt.pending     = 2'd1;
      end else begin
        emit = 1'b1;
        ev   = build_msg(st.status, byte_in, 8'h00);
      end
    end
  end

endmodule

### sv/midi_stream_event_parser.sv
// An event's last byte is held in the input register, decoded, and the event is then held in the output register.
// Throughput: one byte per cycle unless an event waits on a full output; the single decode stage sets that figure.
// A byte that produces no event never waits on the output side.
// Reset (rst_n low, synchronous) clears running status, the pending count,
// the first parameter and both valid flags.
// ----------------------------------------------------------------------------
// MIDI stream event parser
// Input register, combinational byte decode and an output register with
// valid/ready flow control on both sides.
// ----------------------------------------------------------------------------
module midi_stream_event_parser
  import msep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_event_opcode,
  output logic [4:0] out_event_channel,
  output logic [7:0] out_param_a,
  output logic [7:0] out_param_b
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  msep_state_t st_r;
  msep_state_t st_nxt;
  logic        emit;
  msep_event_t ev;
  logic        out_valid_r;
  msep_event_t out_ev_r;
  logic        adv;
  logic        out_load;

  // Decode of the registered byte
  msep_decode u_decode (
    .st      (st_r),
    .byte_in (in_byte_r),
    .st_nxt  (st_nxt),
    .emit    (emit),
    .ev      (ev)
  );

  // The stage moves on unless it holds an event and the output is still full.
  assign adv      = in_valid_r && (!emit || !out_valid_r || out_ready);
  assign out_load = adv && emit;
  assign in_ready = !in_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ev_r <= ev;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_opcode  = out_ev_r.opcode;
  assign out_event_channel = out_ev_r.channel;
  assign out_param_a       = out_ev_r.param_a;
  assign out_param_b       = out_ev_r.param_b;

endmodule
